// ===== hdl/hsl2rgb_pkg.sv =====
// Package for the HSL to RGB converter: Q16 constants, field widths,
// hue segment codes and the stage payload types.
// No dependencies.
package hsl2rgb_pkg;

   localparam int NUM_CHAN   = 3;
   localparam int PIPE_DEPTH = 5;

   localparam int HUE_W  = 9;
   localparam int FRAC_W = 9;
   localparam int CHAN_W = 8;

   localparam int Q_FRAC    = 16;
   localparam int HUE16_W   = 17;
   localparam int HUE_OFF_W = 19;
   localparam int LS_W      = 18;
   localparam int VAL_W     = 21;
   localparam int FACT_W    = 17;
   localparam int PROD_W    = VAL_W + FACT_W + 1;
   localparam int LVL_W     = 23;

   // hue16 = floor(h * 65536 / 360) = (h * ceil(2^28 / 45)) >> 15, exact for h < 512
   localparam int             HUE_PROD_W = 32;
   localparam int             HUE_SHIFT  = 15;
   localparam logic [22:0]    HUE_RECIP  = 23'd5965233;

   localparam logic [FRAC_W-1:0] L_HALF = 9'd128;

   localparam logic signed [HUE_OFF_W-1:0] Q_ONE = 19'sd65536;
   localparam logic signed [HUE_OFF_W-1:0] HUE_OFFSET [NUM_CHAN] =
      '{19'sd21845, 19'sd0, -19'sd21845};

   // segment limits on the wrapped hue: 6h < 1, 2h < 1, 3h < 2
   localparam logic [HUE16_W-1:0] LIM_SIXTH     = 17'd10923;
   localparam logic [HUE16_W-1:0] LIM_HALF      = 17'd32768;
   localparam logic [HUE16_W-1:0] LIM_TWOTHIRDS = 17'd43691;

   localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hFF;

   typedef logic [1:0] seg_type;
   localparam seg_type SEG_RISE = 2'd0;
   localparam seg_type SEG_HIGH = 2'd1;
   localparam seg_type SEG_FALL = 2'd2;
   localparam seg_type SEG_LOW  = 2'd3;

   typedef logic signed [VAL_W-1:0] val_type;
   typedef logic [FACT_W-1:0]       fact_type;

   typedef struct packed {
      val_type v1;
      val_type v2;
      val_type diff;
   } span_type;

   typedef struct packed {
      seg_type  seg;
      fact_type factor;
   } hue_sel_type;

endpackage

// ===== hdl/hsl2rgb_front.sv =====
// Front end of the HSL to RGB pipeline: hue scaling and l*s products,
// then the two HSL levels and the per-channel hue segment and ramp factor.
// Depends on hsl2rgb_pkg.
module hsl2rgb_front import hsl2rgb_pkg::*; (
   input  logic                             clock,
   input  logic                             adv,
   input  logic [HUE_W-1:0]                 hue_degrees,
   input  logic [FRAC_W-1:0]                saturation,
   input  logic [FRAC_W-1:0]                lightness,
   output span_type                         span,
   output hue_sel_type [NUM_CHAN-1:0]       sel
);

   logic [HUE_PROD_W-1:0]       hue_prod;
   logic [HUE16_W-1:0]          hue16_in, hue16_ff;
   logic [LS_W-1:0]             ls_in, ls_ff;
   logic [FRAC_W-1:0]           l_ff, s_ff;

   val_type                     l16, s16, ls, rise;
   span_type                    span_in, span_ff;
   hue_sel_type [NUM_CHAN-1:0]  sel_in, sel_ff;

   assign hue_prod = HUE_PROD_W'(hue_degrees) * HUE_PROD_W'(HUE_RECIP);
   assign hue16_in = hue_prod[HUE_SHIFT +: HUE16_W];
   assign ls_in    = LS_W'(lightness) * LS_W'(saturation);

   always_ff @(posedge clock) begin
      if (adv) begin
         hue16_ff <= hue16_in;
         ls_ff    <= ls_in;
         l_ff     <= lightness;
         s_ff     <= saturation;
      end
   end

   assign l16 = {{(VAL_W-FRAC_W-8){1'b0}}, l_ff, 8'b0};
   assign s16 = {{(VAL_W-FRAC_W-8){1'b0}}, s_ff, 8'b0};
   assign ls  = {{(VAL_W-LS_W){1'b0}}, ls_ff};

   always_comb begin
      if (l_ff < L_HALF) begin
         rise = ls;
      end else begin
         rise = s16 - ls;
      end
      span_in.v2   = l16 + rise;
      span_in.v1   = l16 - rise;
      span_in.diff = rise <<< 1;
   end

   always_comb begin
      logic signed [HUE_OFF_W-1:0] vh_raw;
      logic [HUE16_W-1:0]          vh;
      logic [HUE16_W-1:0]          ramp;
      logic [HUE16_W+2:0]          times6;
      for (int c = 0; c < NUM_CHAN; c++) begin
         vh_raw = $signed({{(HUE_OFF_W-HUE16_W){1'b0}}, hue16_ff}) + HUE_OFFSET[c];
         if (vh_raw < 0) begin
            vh_raw = vh_raw + Q_ONE;
         end else if (vh_raw > Q_ONE) begin
            vh_raw = vh_raw - Q_ONE;
         end
         vh = vh_raw[HUE16_W-1:0];
         if (vh < LIM_SIXTH) begin
            sel_in[c].seg = SEG_RISE;
            ramp          = vh;
         end else if (vh < LIM_HALF) begin
            sel_in[c].seg = SEG_HIGH;
            ramp          = '0;
         end else if (vh < LIM_TWOTHIRDS) begin
            sel_in[c].seg = SEG_FALL;
            ramp          = LIM_TWOTHIRDS - vh;
         end else begin
            sel_in[c].seg = SEG_LOW;
            ramp          = '0;
         end
         times6           = {ramp, 2'b0} + {1'b0, ramp, 1'b0};
         sel_in[c].factor = times6[FACT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         span_ff <= span_in;
         sel_ff  <= sel_in;
      end
   end

   assign span = span_ff;
   assign sel  = sel_ff;

endmodule

// ===== hdl/hsl2rgb_channel.sv =====
// One color channel of the HSL to RGB pipeline: ramp product, level select
// and scaling to an 8-bit saturated intensity.
// Depends on hsl2rgb_pkg.
module hsl2rgb_channel import hsl2rgb_pkg::*; (
   input  logic              clock,
   input  logic              adv,
   input  span_type          span,
   input  hue_sel_type       sel,
   output logic [CHAN_W-1:0] chan
);

   logic signed [PROD_W-1:0]  prod_in, prod_ff, term;
   val_type                   v1_ff, v2_ff;
   seg_type                   seg_ff;
   logic signed [LVL_W-1:0]   level_in, level_ff;
   logic [LVL_W-2:0]          lv;
   logic [LVL_W+6:0]          scaled;
   logic [LVL_W-10:0]         whole;
   logic [CHAN_W-1:0]         chan_in, chan_ff;

   assign prod_in = PROD_W'(span.diff) * PROD_W'($signed({1'b0, sel.factor}));

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff <= prod_in;
         v1_ff   <= span.v1;
         v2_ff   <= span.v2;
         seg_ff  <= sel.seg;
      end
   end

   // floor to Q16
   assign term = prod_ff >>> Q_FRAC;

   always_comb begin
      case (seg_ff)
         SEG_RISE, SEG_FALL: level_in = LVL_W'(v1_ff) + LVL_W'(term);
         SEG_HIGH:           level_in = LVL_W'(v2_ff);
         default:            level_in = LVL_W'(v1_ff);
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         level_ff <= level_in;
      end
   end

   // 255 * level, then drop the fraction
   assign lv     = level_ff[LVL_W-2:0];
   assign scaled = {lv, 8'b0} - {8'b0, lv};
   assign whole  = scaled[LVL_W+6:Q_FRAC];

   always_comb begin
      if (level_ff <= 0) begin
         chan_in = '0;
      end else if (whole > (LVL_W-9)'(CHAN_MAX)) begin
         chan_in = CHAN_MAX;
      end else begin
         chan_in = whole[CHAN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         chan_ff <= chan_in;
      end
   end

   assign chan = chan_ff;

endmodule

// ===== hdl/hsl_to_rgb_converter.sv =====
// Top level of the HSL to RGB converter: stream ports, valid pipeline and
// stall control around the front end and three channel units.
// Depends on hsl2rgb_pkg, hsl2rgb_front, hsl2rgb_channel.
//
//   channel   direction   transaction
//   req_      in          one color: hue, saturation, lightness
//   rsp_      out         one red, green, blue triple
//
// Five register stages; one transaction enters per clock while the output
// is not stalled.
// The whole pipeline advances together whenever the output stage is empty
// or being taken; a stall freezes every stage, nothing is lost.
// Synchronous reset clears the valid bits only.
module hsl_to_rgb_converter import hsl2rgb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // hue_degrees[8:0], saturation[17:9], lightness[26:18]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // red[7:0], green[15:8], blue[23:16]
);

   logic                              adv;
   logic [PIPE_DEPTH-1:0]             vld_in, vld_ff;
   span_type                          span;
   hue_sel_type [NUM_CHAN-1:0]        sel;
   logic [NUM_CHAN-1:0][CHAN_W-1:0]   chan;

   assign adv = !vld_ff[PIPE_DEPTH-1] || rsp_tready;

   always_comb begin
      vld_in = vld_ff;
      if (adv) begin
         vld_in = {vld_ff[PIPE_DEPTH-2:0], req_tvalid};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   hsl2rgb_front u_front (
      .clock       (clock),
      .adv         (adv),
      .hue_degrees (req_tdata[8:0]),
      .saturation  (req_tdata[17:9]),
      .lightness   (req_tdata[26:18]),
      .span        (span),
      .sel         (sel)
   );

   for (genvar c = 0; c < NUM_CHAN; c++) begin : g_chan
      hsl2rgb_channel u_channel (
         .clock (clock),
         .adv   (adv),
         .span  (span),
         .sel   (sel[c]),
         .chan  (chan[c])
      );
   end

   assign req_tready = adv;
   assign rsp_tvalid = vld_ff[PIPE_DEPTH-1];
   assign rsp_tdata  = chan;

endmodule

// ===== hdl/hsl2rgb_checker.sv =====
// Port-level checks for the HSL to RGB converter, attached by bind.
// Depends on hsl_to_rgb_converter.
module hsl2rgb_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata
);

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed or dropped");

   // drop everything on reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // accept while the output side is empty
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input blocked with empty output");

   // advance an accepted transaction to the output when the output is not stalled
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) ##1 rsp_tready ##1 rsp_tready ##1 rsp_tready
         ##1 rsp_tready |=> rsp_tvalid)
      else $error("accepted transaction did not reach the output");

endmodule

bind hsl_to_rgb_converter hsl2rgb_checker u_hsl2rgb_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== bench/testbench.sv =====
// Self-checking bench for hsl_to_rgb_converter: directed and random colors are
// streamed in, and each red, green, blue result is checked against a Q16 model.
// Depends on hsl2rgb_pkg and the converter RTL.
`timescale 1ns / 100ps

module testbench;

   localparam int     HW = hsl2rgb_pkg::HUE_W;
   localparam int     FW = hsl2rgb_pkg::FRAC_W;
   localparam int     CW = hsl2rgb_pkg::CHAN_W;
   localparam longint Q16_ONE       = 65536;
   localparam longint Q16_HALF      = 32768;
   localparam longint Q16_THIRD     = 21845;
   localparam longint Q16_TWOTHIRDS = 43691;
   localparam int     REPORT_LIMIT  = 10;

   typedef struct packed {
      logic [CW-1:0] blue;
      logic [CW-1:0] green;
      logic [CW-1:0] red;
   } rgb_type;

   class color_board;
      rgb_type pending_rgb[$];
      int      mismatches = 0;

      function longint hue_level(longint v1, longint v2, longint vh_in);
         longint vh;
         vh = vh_in;
         if (vh < 0) vh += Q16_ONE;
         if (vh > Q16_ONE) vh -= Q16_ONE;
         if (6 * vh < Q16_ONE) return v1 + (((v2 - v1) * 6 * vh) >>> 16);
         if (2 * vh < Q16_ONE) return v2;
         if (3 * vh < 2 * Q16_ONE) return v1 + (((v2 - v1) * (Q16_TWOTHIRDS - vh) * 6) >>> 16);
         return v1;
      endfunction

      function logic [CW-1:0] channel_of(longint v);
         longint c;
         if (v <= 0) return '0;
         c = (255 * v) / Q16_ONE;
         if (c > 255) c = 255;
         return c[CW-1:0];
      endfunction

      function rgb_type convert_hsl(logic [HW-1:0] hue_deg, logic [FW-1:0] sat,
                                    logic [FW-1:0] lit);
         longint  h, s, l, g, s16, l16, ls, hue, v1, v2;
         rgb_type rgb;
         h = hue_deg;
         s = sat;
         l = lit;
         if (s == 0) begin
            g = (l * 255) / 256;
            if (g > 255) g = 255;
            rgb.red   = g[CW-1:0];
            rgb.green = g[CW-1:0];
            rgb.blue  = g[CW-1:0];
            return rgb;
         end
         s16 = s * 256;
         l16 = l * 256;
         ls  = l * s;
         hue = (h * Q16_ONE) / 360;
         v2  = (l16 < Q16_HALF) ? l16 + ls : l16 + s16 - ls;
         v1  = 2 * l16 - v2;
         rgb.red   = channel_of(hue_level(v1, v2, hue + Q16_THIRD));
         rgb.green = channel_of(hue_level(v1, v2, hue));
         rgb.blue  = channel_of(hue_level(v1, v2, hue - Q16_THIRD));
         return rgb;
      endfunction

      function void note_color(logic [HW-1:0] h, logic [FW-1:0] s, logic [FW-1:0] l);
         pending_rgb = {pending_rgb, convert_hsl(h, s, l)};
      endfunction

      function void tally(string what, int want, int got);
         mismatches++;
         if (mismatches <= REPORT_LIMIT)
            $display("mismatch at %0t: %s expected %0d got %0d", $time, what, want, got);
      endfunction

      function void check_rgb(rgb_type got);
         rgb_type want;
         if (pending_rgb.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("mismatch at %0t: result %h with no color outstanding", $time, got);
            return;
         end
         want = pending_rgb.pop_front();
         if (got.red !== want.red) tally("red", want.red, got.red);
         if (got.green !== want.green) tally("green", want.green, got.green);
         if (got.blue !== want.blue) tally("blue", want.blue, got.blue);
      endfunction

      function int outstanding();
         return pending_rgb.size();
      endfunction

      function bit failed();
         return mismatches != 0 || pending_rgb.size() != 0;
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;

   color_board board = new();
   int         idle_pct = 30;
   bit         calm = 1'b0;

   hsl_to_rgb_converter u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            board.note_color(req_tdata[8:0], req_tdata[17:9], req_tdata[26:18]);
         if (rsp_tvalid && rsp_tready)
            board.check_rgb(rsp_tdata);
      end
   end

   // hold off the result side in random bursts
   initial begin
      do @(posedge clock); while (reset);
      forever begin
         if (!calm && $urandom_range(0, 99) < idle_pct) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   end

   task automatic send_color(input logic [HW-1:0] h, input logic [FW-1:0] s,
                             input logic [FW-1:0] l);
      if (!calm && $urandom_range(0, 99) < idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {5'd0, l, s, h};
      do @(posedge clock); while (!req_tready);
   endtask

   function automatic logic [FW-1:0] pick_fraction();
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) return '0;
      if (r == 1) return 9'd256;
      if (r == 2) return FW'($urandom_range(257, 511));
      return FW'($urandom_range(1, 255));
   endfunction

   task automatic send_random();
      logic [HW-1:0] h;
      h = ($urandom_range(0, 9) == 0) ? HW'($urandom_range(360, 511))
                                      : HW'($urandom_range(0, 359));
      send_color(h, pick_fraction(), pick_fraction());
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // grey, including lightness past one
      send_color(0, 0, 0);
      send_color(0, 0, 256);
      send_color(0, 0, 511);
      send_color(0, 0, 128);
      send_color(511, 511, 511);
      // hue sweep across segment edges
      send_color(0, 256, 128);
      send_color(60, 256, 128);
      send_color(120, 256, 128);
      send_color(180, 256, 128);
      send_color(240, 256, 128);
      send_color(300, 256, 128);
      send_color(359, 256, 128);
      // hue past one turn; blue lands exactly on one after wrap
      send_color(360, 256, 128);
      send_color(480, 256, 128);
      send_color(480, 256, 64);
      // lightness extremes and out-of-range fractions
      send_color(0, 256, 256);
      send_color(0, 256, 0);
      send_color(90, 1, 127);
      send_color(200, 511, 100);
      send_color(30, 300, 300);
      send_color(150, 128, 511);
      send_color(270, 255, 255);

      for (int i = 0; i < 400; i++) begin
         if (i % 50 == 0) begin
            case ($urandom_range(0, 2))
               0: idle_pct = 0;
               1: idle_pct = 20;
               default: idle_pct = 50;
            endcase
         end
         if (i >= 340) calm = 1'b1;
         send_random();
      end
      req_tvalid <= 1'b0;

      // drain
      while (board.outstanding() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (board.failed())
         $display("testbench: errors");
      else
         $display("testbench: clean");
      $finish;
   end

   initial begin
      #1_000_000;
      $display("testbench: errors");
      $finish;
   end

endmodule
